@@ rtl/core/scrt_pkg.sv @@
package scrt_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 16;
    localparam int COUNT_BITS = 8;

    // fixed port field widths
    localparam int KEY_IN_BITS = 16;
    localparam int SLOT_BITS   = 4;
    localparam int ENTRY_BITS  = 4;
    localparam int REFS_BITS   = 8;
    localparam int STATUS_BITS = 3;

    localparam int IDX_BITS  = $clog2(ENTRIES);
    localparam int SCAN_BITS = IDX_BITS + 1;
    localparam int SEL_BITS  = ((IDX_BITS > SLOT_BITS) ? IDX_BITS : SLOT_BITS) + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [STATUS_BITS-1:0] {
        ST_HIT      = 3'd0,
        ST_NEW      = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_HELD     = 3'd3,
        ST_FREED    = 3'd4,
        ST_BAD      = 3'd5
    } t_status;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] cnt;
    } t_word;

    typedef struct packed {
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_addr;
        t_word               wr_data;
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        t_status               status;
        logic [ENTRY_BITS-1:0] entry;
        logic [REFS_BITS-1:0]  refs;
    } t_res;

endpackage

@@ rtl/core/scrt_mem.sv @@
module scrt_mem
    import scrt_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_word    o_rd_data
);

    t_word r_mem [ENTRIES];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/scrt_ctrl.sv @@
module scrt_ctrl
    import scrt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_op,
    input  logic [KEY_IN_BITS-1:0] i_key,
    input  logic [SLOT_BITS-1:0]   i_slot,
    input  logic                   i_out_free,
    output logic                   o_res_valid,
    output t_res                   o_res,
    output t_mem_req               o_mem_req,
    input  t_word                  i_rd_data
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_REL_RD  = 6'b000100,
        S_REL_CHK = 6'b001000,
        S_WRITE   = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [ENTRIES-1:0]    r_used, n_used;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [SLOT_BITS-1:0]  r_slot, n_slot;
    logic [SCAN_BITS-1:0]  r_cnt, n_cnt;
    logic                  r_chk_vld, n_chk_vld;
    logic [IDX_BITS-1:0]   r_chk_idx, n_chk_idx;
    logic                  r_have_free, n_have_free;
    logic [IDX_BITS-1:0]   r_free_idx, n_free_idx;
    logic [IDX_BITS-1:0]   r_wr_idx, n_wr_idx;
    t_word                 r_wr_word, n_wr_word;
    t_res                  r_res, n_res;

    logic                  issue;
    logic                  chk_used;
    logic                  is_free;
    logic                  is_hit;
    logic                  is_last;
    logic                  free_any;
    logic [IDX_BITS-1:0]   free_idx;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic [SEL_BITS-1:0]   slot_ext;
    logic [IDX_BITS-1:0]   slot_idx;
    logic                  slot_ok;

    assign slot_ext = SEL_BITS'(r_slot);
    assign slot_idx = slot_ext[IDX_BITS-1:0];
    assign slot_ok  = slot_ext < SEL_BITS'(ENTRIES);

    assign issue    = (r_state == S_SCAN) && (r_cnt < SCAN_BITS'(ENTRIES));
    assign chk_used = r_used[r_chk_idx];
    assign is_free  = r_chk_vld && !chk_used;
    assign is_hit   = r_chk_vld && chk_used && (i_rd_data.key == r_key);
    assign is_last  = r_chk_vld && (r_chk_idx == IDX_BITS'(ENTRIES - 1));
    assign free_any = r_have_free || is_free;
    assign free_idx = r_have_free ? r_free_idx : r_chk_idx;
    assign cnt_inc  = (i_rd_data.cnt == COUNT_MAX) ? i_rd_data.cnt
                                                   : i_rd_data.cnt + COUNT_BITS'(1);
    assign cnt_dec  = i_rd_data.cnt - COUNT_BITS'(1);

    always_comb begin
        o_mem_req         = '0;
        o_mem_req.rd_en   = issue || (r_state == S_REL_RD);
        o_mem_req.rd_addr = (r_state == S_REL_RD) ? slot_idx : r_cnt[IDX_BITS-1:0];
        o_mem_req.wr_en   = (r_state == S_WRITE);
        o_mem_req.wr_addr = r_wr_idx;
        o_mem_req.wr_data = r_wr_word;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_key       = r_key;
        n_slot      = r_slot;
        n_cnt       = r_cnt;
        n_chk_vld   = 1'b0;
        n_chk_idx   = r_cnt[IDX_BITS-1:0];
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_wr_idx    = r_wr_idx;
        n_wr_word   = r_wr_word;
        n_res       = r_res;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key       = KEY_BITS'(i_key);
                    n_slot      = i_slot;
                    n_cnt       = '0;
                    n_have_free = 1'b0;
                    n_state     = (t_op'(i_op) == OP_ACQUIRE) ? S_SCAN : S_REL_RD;
                end
            end
            S_SCAN: begin
                // read runs one entry ahead of the compare
                n_chk_vld = issue;
                if (issue) begin
                    n_cnt = r_cnt + SCAN_BITS'(1);
                end
                if (is_hit) begin
                    n_wr_idx  = r_chk_idx;
                    n_wr_word = '{key: r_key, cnt: cnt_inc};
                    n_res     = '{status: ST_HIT, entry: ENTRY_BITS'(r_chk_idx),
                                  refs: REFS_BITS'(cnt_inc)};
                    n_state   = S_WRITE;
                end else if (is_last) begin
                    if (free_any) begin
                        n_used[free_idx] = 1'b1;
                        n_wr_idx  = free_idx;
                        n_wr_word = '{key: r_key, cnt: COUNT_BITS'(1)};
                        n_res     = '{status: ST_NEW, entry: ENTRY_BITS'(free_idx),
                                      refs: REFS_BITS'(1)};
                        n_state   = S_WRITE;
                    end else begin
                        n_res   = '{status: ST_OVERFLOW, entry: '0, refs: '0};
                        n_state = S_DONE;
                    end
                end else if (is_free && !r_have_free) begin
                    n_have_free = 1'b1;
                    n_free_idx  = r_chk_idx;
                end
            end
            S_REL_RD: begin
                n_state = S_REL_CHK;
            end
            S_REL_CHK: begin
                if (!slot_ok || !r_used[slot_idx] || (i_rd_data.cnt == '0)) begin
                    n_res   = '{status: ST_BAD, entry: ENTRY_BITS'(r_slot), refs: '0};
                    n_state = S_DONE;
                end else if (cnt_dec == '0) begin
                    // count of a free entry is never read, no write-back needed
                    n_used[slot_idx] = 1'b0;
                    n_res   = '{status: ST_FREED, entry: ENTRY_BITS'(r_slot), refs: '0};
                    n_state = S_DONE;
                end else begin
                    n_wr_idx  = slot_idx;
                    n_wr_word = '{key: i_rd_data.key, cnt: cnt_dec};
                    n_res     = '{status: ST_HELD, entry: ENTRY_BITS'(r_slot),
                                  refs: REFS_BITS'(cnt_dec)};
                    n_state   = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_chk_vld <= n_chk_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_slot      <= n_slot;
        r_cnt       <= n_cnt;
        r_chk_idx   <= n_chk_idx;
        r_have_free <= n_have_free;
        r_free_idx  <= n_free_idx;
        r_wr_idx    <= n_wr_idx;
        r_wr_word   <= n_wr_word;
        r_res       <= n_res;
    end

    a_idle_used_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_used))
        else $error("used bits changed while idle");

    a_write_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> r_used[r_wr_idx])
        else $error("write-back to a free entry");

    a_write_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en |-> (o_mem_req.wr_data.cnt != '0))
        else $error("zero count written back");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.wr_en |-> !o_mem_req.rd_en)
        else $error("read and write in the same cycle");

endmodule

@@ rtl/core/shared_segment_refcount_table.sv @@
// Acquire: the scan reads one entry per cycle and stops at a hit, allocation writes back after a full
// scan, and overflow skips the write-back. Release skips the write-back when the slot is bad or freed.
// One request in flight; the next input is accepted the cycle after the result is loaded
// into the output register.
// Synchronous active-low reset clears the used bits and the handshake state only.
module shared_segment_refcount_table
    import scrt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_op,
    input  logic [KEY_IN_BITS-1:0] i_key,
    input  logic [SLOT_BITS-1:0]   i_slot,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [STATUS_BITS-1:0] o_status,
    output logic [ENTRY_BITS-1:0]  o_entry,
    output logic [REFS_BITS-1:0]   o_refs
);

    t_mem_req mem_req;
    t_word    rd_data;
    t_res     res;
    logic     res_valid;
    logic     out_free;

    logic     r_o_valid;
    t_res     r_o_res;

    assign out_free = !r_o_valid || i_ready;

    scrt_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    scrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_slot      (i_slot),
        .i_out_free  (out_free),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_req   (mem_req),
        .i_rd_data   (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_o_res <= res;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_o_res.status;
    assign o_entry  = r_o_res.entry;
    assign o_refs   = r_o_res.refs;

endmodule

@@ verif/shared_segment_refcount_table_checker.sv @@
module shared_segment_refcount_table_checker
    import scrt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic                   i_op,
    input  logic [KEY_IN_BITS-1:0] i_key,
    input  logic [SLOT_BITS-1:0]   i_slot,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [STATUS_BITS-1:0] i_status,
    input  logic [ENTRY_BITS-1:0]  i_entry,
    input  logic [REFS_BITS-1:0]   i_refs,
    output int                     o_fail_count,
    output int                     o_outstanding
);

    logic [KEY_BITS-1:0]   tab_key  [ENTRIES];
    logic                  tab_used [ENTRIES];
    logic [COUNT_BITS-1:0] tab_refs [ENTRIES];

    t_res pending_results[$];
    int   fails = 0;

    function automatic t_res acquire_key(logic [KEY_IN_BITS-1:0] key);
        logic [KEY_BITS-1:0] k;
        int                  free_idx;
        bit                  have_free;
        t_res                r;
        k         = KEY_BITS'(key);
        free_idx  = 0;
        have_free = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!tab_used[i]) begin
                if (!have_free) begin
                    free_idx  = i;
                    have_free = 1'b1;
                end
            end else if (tab_key[i] == k) begin
                // saturating count, still reported as a hit
                if (tab_refs[i] != COUNT_MAX)
                    tab_refs[i] = tab_refs[i] + 1'b1;
                r.status = ST_HIT;
                r.entry  = ENTRY_BITS'(i);
                r.refs   = REFS_BITS'(tab_refs[i]);
                return r;
            end
        end
        if (!have_free) begin
            r.status = ST_OVERFLOW;
            r.entry  = '0;
            r.refs   = '0;
            return r;
        end
        tab_used[free_idx] = 1'b1;
        tab_key[free_idx]  = k;
        tab_refs[free_idx] = COUNT_BITS'(1);
        r.status = ST_NEW;
        r.entry  = ENTRY_BITS'(free_idx);
        r.refs   = REFS_BITS'(1);
        return r;
    endfunction

    function automatic t_res release_slot(logic [SLOT_BITS-1:0] slot);
        int   s;
        t_res r;
        s       = int'(slot);
        r.entry = ENTRY_BITS'(slot);
        if (s >= ENTRIES) begin
            r.status = ST_BAD;
            r.refs   = '0;
        end else if (!tab_used[s] || tab_refs[s] == '0) begin
            r.status = ST_BAD;
            r.refs   = '0;
        end else begin
            tab_refs[s] = tab_refs[s] - 1'b1;
            if (tab_refs[s] == '0) begin
                tab_used[s] = 1'b0;
                r.status    = ST_FREED;
                r.refs      = '0;
            end else begin
                r.status = ST_HELD;
                r.refs   = REFS_BITS'(tab_refs[s]);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tab_key[i]  = '0;
                tab_used[i] = 1'b0;
                tab_refs[i] = '0;
            end
            pending_results.delete();
        end else begin
            // request side first, so a same-edge result still pops the older entry
            if (i_req_valid && i_req_ready) begin
                if (t_op'(i_op) == OP_ACQUIRE)
                    pending_results.push_back(acquire_key(i_key));
                else
                    pending_results.push_back(release_slot(i_slot));
            end
            if (i_res_valid && i_res_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transaction: status %0d entry %0d refs %0d",
                           i_status, i_entry, i_refs);
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fails++;
                    end
                    if (i_entry !== want.entry) begin
                        $error("entry: expected %0d, actual %0d", want.entry, i_entry);
                        fails++;
                    end
                    if (i_refs !== want.refs) begin
                        $error("refs: expected %0d, actual %0d", want.refs, i_refs);
                        fails++;
                    end
                end
            end
        end
        o_outstanding <= pending_results.size();
        o_fail_count  <= fails;
    end

endmodule

@@ verif/shared_segment_refcount_table_tb.sv @@
module shared_segment_refcount_table_tb;
    import scrt_pkg::*;

    localparam int POOL_SIZE   = 24;
    localparam int PHASE_ITEMS = 65;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic                   i_op;
    logic [KEY_IN_BITS-1:0] i_key;
    logic [SLOT_BITS-1:0]   i_slot;
    logic                   o_valid;
    logic                   i_ready;
    logic [STATUS_BITS-1:0] o_status;
    logic [ENTRY_BITS-1:0]  o_entry;
    logic [REFS_BITS-1:0]   o_refs;

    int fail_count;
    int outstanding;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int hold_request = 0;
    int req_count    = 0;

    logic [KEY_IN_BITS-1:0] key_pool [POOL_SIZE];

    always #2 i_clk = ~i_clk;

    shared_segment_refcount_table u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_op     (i_op),
        .i_key    (i_key),
        .i_slot   (i_slot),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_status (o_status),
        .o_entry  (o_entry),
        .o_refs   (o_refs)
    );

    shared_segment_refcount_table_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_op          (i_op),
        .i_key         (i_key),
        .i_slot        (i_slot),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_status      (o_status),
        .i_entry       (o_entry),
        .i_refs        (o_refs),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // called right after a rising edge; returns at the edge that accepts the transaction
    task automatic send_request(input t_op op, input logic [KEY_IN_BITS-1:0] key,
                                input logic [SLOT_BITS-1:0] slot);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_key   <= key;
        i_slot  <= slot;
        do @(posedge i_clk); while (!o_ready);
        req_count++;
    endtask

    task automatic acquire(input logic [KEY_IN_BITS-1:0] key);
        send_request(OP_ACQUIRE, key, SLOT_BITS'($urandom));
    endtask

    task automatic send_release(input logic [SLOT_BITS-1:0] slot);
        send_request(OP_RELEASE, KEY_IN_BITS'($urandom), slot);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic random_request();
        int                     pick;
        logic [KEY_IN_BITS-1:0] k;
        pick = $urandom_range(99);
        k    = key_pool[$urandom_range(POOL_SIZE - 1)];
        if (pick < 10)
            repeat ($urandom_range(5, 2)) acquire(k);
        else if (pick < 50)
            acquire(k);
        else if (pick < 58)
            acquire(KEY_IN_BITS'($urandom));
        else
            send_release(SLOT_BITS'($urandom));
    endtask

    // receiver; a long hold-off is counted here once requested
    initial begin
        int hold_left;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        #2000000;
        $display("shared_segment_refcount_table_tb NOT OK");
        $finish;
    end

    initial begin
        int phase_idle  [4];
        int phase_stall [4];
        int target;
        phase_idle  = '{0, 77, 0, 12};
        phase_stall = '{0, 0, 77, 12};
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op    <= OP_ACQUIRE;
        i_key   <= '0;
        i_slot  <= '0;
        foreach (key_pool[i])
            key_pool[i] = KEY_IN_BITS'($urandom);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: alloc, hit, free, bad releases, fill, overflow, hit when full
        acquire(16'h0000);
        acquire(16'hFFFF);
        acquire(16'h0000);
        send_release(4'd1);
        send_release(4'd1);
        send_release(4'd15);
        send_release(4'd0);
        acquire(16'hA5A5);
        for (int i = 2; i < ENTRIES; i++)
            acquire(16'h5A00 + KEY_IN_BITS'(i));
        acquire(16'h1234);
        acquire(16'hA5A5);
        send_release(4'd0);
        acquire(16'h1234);
        drain();

        // drive slot 0 into saturation, then step it back down once
        repeat (260) acquire(16'h1234);
        send_release(4'd0);
        drain();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            if (p == 0)
                hold_request = 300;
            target = req_count + PHASE_ITEMS;
            while (req_count < target)
                random_request();
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0)
            $display("shared_segment_refcount_table_tb OK");
        else
            $display("shared_segment_refcount_table_tb NOT OK");
        $finish;
    end

endmodule
